@@ hdl/short_run_boundary_flattener_assert.svh @@
`ifndef SHORT_RUN_BOUNDARY_FLATTENER_ASSERT_SVH
`define SHORT_RUN_BOUNDARY_FLATTENER_ASSERT_SVH

// next-cycle implication, ignored while in reset
`define SRBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srbf check failed");

// next-cycle implication, also checked out of reset
`define SRBF_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("srbf reset check failed");

`endif

@@ hdl/srbf_pkg.sv @@
package srbf_pkg;

  localparam int S_W     = 21;
  localparam int LAT_W   = 17;
  localparam int THR_W   = 13;
  localparam int LEN_W   = 16;
  localparam int ACC_W   = 24;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_THR = 1'b0;
  localparam logic REG_LEN = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 13'd1650;
  localparam logic [LEN_W-1:0] LEN_RESET = 16'd3000;

  typedef struct packed {
    logic [THR_W-1:0] extend_threshold;
    logic [LEN_W-1:0] short_run_length;
  } cfg_t;

  typedef struct packed {
    logic                    en;
    logic                    sub;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
  } alu_op_t;

endpackage

@@ hdl/srbf_if.sv @@
interface srbf_in_if;
  logic              valid;
  logic              ready;
  logic signed [20:0] station_s;
  logic signed [16:0] inner_lat;
  logic signed [16:0] outer_lat;
  logic              last_station;

  modport source (output valid, station_s, inner_lat, outer_lat, last_station,
                  input ready);
  modport sink (input valid, station_s, inner_lat, outer_lat, last_station,
                output ready);
endinterface

interface srbf_out_if;
  logic              valid;
  logic              ready;
  logic signed [16:0] outer_lat_out;
  logic              was_replaced;
  logic              last_result;

  modport source (output valid, outer_lat_out, was_replaced, last_result,
                  input ready);
  modport sink (input valid, outer_lat_out, was_replaced, last_result,
                output ready);
endinterface

@@ hdl/short_run_boundary_flattener.sv @@
// channel    | role   | payload
// stations   | sink   | station_s, inner_lat, outer_lat, last_station
// results    | source | outer_lat_out, was_replaced, last_result
// apb        | slave  | extend_threshold at 0x0, short_run_length at 0x4
//
// one station at a time: shared adder steps (plus span and length steps when a
// run closes), a decision step, a read then a transfer per held station flushed
// from the run store, then the station itself when it is emitted, then an end step
// synchronous reset clears control state; the run store is not cleared
// a stalled results channel holds the sequencer at its current transfer
module short_run_boundary_flattener #(
  parameter int RUN_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  srbf_in_if.sink                           stations,
  srbf_out_if.source                        results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srbf_pkg::PADDR_W-1:0]      paddr,
  input  logic [srbf_pkg::PDATA_W-1:0]      pwdata,
  output logic [srbf_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import srbf_pkg::*;

  localparam int AW = $clog2(RUN_DEPTH);

  cfg_t                    cfg;
  alu_op_t                 op;
  logic signed [ACC_W-1:0] acc;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [LAT_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [LAT_W-1:0]        ram_rdata;

  srbf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srbf_alu u_alu (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  srbf_ram #(
    .WIDTH (LAT_W),
    .DEPTH (RUN_DEPTH)
  ) u_run_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srbf_ctrl #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (stations.valid),
    .in_ready  (stations.ready),
    .in_s      (stations.station_s),
    .in_inner  (stations.inner_lat),
    .in_outer  (stations.outer_lat),
    .in_last   (stations.last_station),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_lat   (results.outer_lat_out),
    .out_rep   (results.was_replaced),
    .out_last  (results.last_result),
    .op        (op),
    .acc       (acc),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

@@ hdl/srbf_ram.sv @@
module srbf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/srbf_regs.sv @@
module srbf_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srbf_pkg::PADDR_W-1:0]    paddr,
  input  logic [srbf_pkg::PDATA_W-1:0]    pwdata,
  output logic [srbf_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output srbf_pkg::cfg_t                  cfg
);
  import srbf_pkg::*;

  logic sel;
  logic wr;

  assign sel    = paddr[2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extend_threshold <= THR_RESET;
      cfg.short_run_length <= LEN_RESET;
    end else if (wr) begin
      case (sel)
        REG_THR: cfg.extend_threshold <= pwdata[THR_W-1:0];
        REG_LEN: cfg.short_run_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_THR: prdata = PDATA_W'(cfg.extend_threshold);
      REG_LEN: prdata = PDATA_W'(cfg.short_run_length);
      default: prdata = '0;
    endcase
  end

endmodule

@@ hdl/srbf_alu.sv @@
module srbf_alu (
  input  logic                                clk,
  input  srbf_pkg::alu_op_t                   op,
  output logic signed [srbf_pkg::ACC_W-1:0]   acc
);
  import srbf_pkg::*;

  // shared add/subtract with its result register
  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= op.sub ? (op.a - op.b) : (op.a + op.b);
    end
  end

endmodule

@@ hdl/srbf_ctrl.sv @@
module srbf_ctrl #(
  parameter int RUN_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  srbf_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [srbf_pkg::S_W-1:0]     in_s,
  input  logic signed [srbf_pkg::LAT_W-1:0]   in_inner,
  input  logic signed [srbf_pkg::LAT_W-1:0]   in_outer,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [srbf_pkg::LAT_W-1:0]   out_lat,
  output logic                                out_rep,
  output logic                                out_last,
  output srbf_pkg::alu_op_t                   op,
  input  logic signed [srbf_pkg::ACC_W-1:0]   acc,
  output logic                                ram_we,
  output logic [$clog2(RUN_DEPTH)-1:0]        ram_waddr,
  output logic [srbf_pkg::LAT_W-1:0]          ram_wdata,
  output logic [$clog2(RUN_DEPTH)-1:0]        ram_raddr,
  input  logic [srbf_pkg::LAT_W-1:0]          ram_rdata
);
  import srbf_pkg::*;

  localparam int AW = $clog2(RUN_DEPTH);
  localparam int CW = $clog2(RUN_DEPTH + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_GAP  = 4'd1;
  localparam logic [3:0] ST_EXT  = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_SPAN = 4'd4;
  localparam logic [3:0] ST_LEN  = 4'd5;
  localparam logic [3:0] ST_DEC  = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_PUT  = 4'd8;
  localparam logic [3:0] ST_CUR  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  logic [3:0] state;

  logic signed [S_W-1:0]   s_r;
  logic signed [LAT_W-1:0] inner_r;
  logic signed [LAT_W-1:0] outer_r;
  logic                    last_r;
  logic                    ext;

  logic                    run_open;
  logic [CW-1:0]           run_count;
  logic signed [S_W-1:0]   run_start_s;
  logic signed [S_W-1:0]   run_last_s;
  logic signed [LAT_W-1:0] held_outer;
  logic                    prev_ext;
  logic                    seen_first;

  logic                    flatten;
  logic                    do_flush;
  logic                    emit_cur;
  logic [CW-1:0]           idx;

  logic          out_free;
  logic          load_out;
  logic [CW-1:0] idx_inc;
  logic          idx_end;
  logic          run_room;
  logic          case_grow;
  logic          case_full;
  logic          case_close;
  logic          case_open;
  logic          flush_next;
  logic          emit_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign load_out  = ((state == ST_PUT) || (state == ST_CUR)) && out_free;
  assign idx_inc   = idx + CW'(1);
  assign idx_end   = (idx_inc == run_count);
  assign run_room  = (run_count < CW'(RUN_DEPTH));
  assign ram_raddr = idx[AW-1:0];

  // case split once the station class is known
  always_comb begin
    case_grow  = run_open && ext && run_room;
    case_full  = run_open && ext && !run_room;
    case_close = run_open && !ext;
    case_open  = !run_open && ext && seen_first && !prev_ext;
    flush_next = case_full || case_close || ((case_grow || case_open) && last_r);
    emit_next  = !(case_grow || case_open);
  end

  always_comb begin
    op     = '0;
    op.sub = 1'b1;
    case (state)
      ST_GAP: begin
        op.en = 1'b1;
        op.a  = ACC_W'(inner_r);
        op.b  = ACC_W'(outer_r);
      end
      ST_EXT: begin
        // threshold minus |gap|, negative when extended
        op.en  = 1'b1;
        op.sub = !acc[ACC_W-1];
        op.a   = ACC_W'(cfg.extend_threshold);
        op.b   = acc;
      end
      ST_SPAN: begin
        op.en = 1'b1;
        op.a  = ACC_W'(run_last_s);
        op.b  = ACC_W'(run_start_s);
      end
      ST_LEN: begin
        op.en = 1'b1;
        op.a  = ACC_W'(cfg.short_run_length);
        op.b  = acc;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = (state == ST_DEC) && (case_grow || case_open);
    ram_waddr = case_open ? '0 : run_count[AW-1:0];
    ram_wdata = outer_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      run_open    <= 1'b0;
      run_count   <= '0;
      run_start_s <= '0;
      run_last_s  <= '0;
      held_outer  <= '0;
      prev_ext    <= 1'b0;
      seen_first  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            s_r     <= in_s;
            inner_r <= in_inner;
            outer_r <= in_outer;
            last_r  <= in_last;
            state   <= ST_GAP;
          end
        end
        ST_GAP: state <= ST_EXT;
        ST_EXT: state <= ST_CHK;
        ST_CHK: begin
          ext   <= acc[ACC_W-1];
          state <= (run_open && !acc[ACC_W-1]) ? ST_SPAN : ST_DEC;
        end
        ST_SPAN: state <= ST_LEN;
        ST_LEN:  state <= ST_DEC;
        ST_DEC: begin
          flatten  <= case_close && !acc[ACC_W-1];
          do_flush <= flush_next;
          emit_cur <= emit_next;
          idx      <= '0;
          if (case_grow) begin
            run_count  <= run_count + CW'(1);
            run_last_s <= s_r;
          end
          if (case_open) begin
            run_open    <= 1'b1;
            run_count   <= CW'(1);
            run_start_s <= s_r;
            run_last_s  <= s_r;
          end
          state <= flush_next ? ST_RD : (emit_next ? ST_CUR : ST_FIN);
        end
        ST_RD: state <= ST_PUT;
        ST_PUT: begin
          if (out_free) begin
            out_lat   <= flatten ? held_outer : ram_rdata;
            out_rep   <= flatten;
            out_last  <= last_r && !emit_cur && idx_end;
            idx       <= idx_inc;
            state     <= idx_end ? (emit_cur ? ST_CUR : ST_FIN) : ST_RD;
          end
        end
        ST_CUR: begin
          if (out_free) begin
            out_lat    <= outer_r;
            out_rep    <= 1'b0;
            out_last   <= last_r;
            held_outer <= outer_r;
            state      <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (do_flush || last_r) begin
            run_open  <= 1'b0;
            run_count <= '0;
          end
          if (last_r) begin
            run_start_s <= '0;
            run_last_s  <= '0;
            held_outer  <= '0;
            prev_ext    <= 1'b0;
            seen_first  <= 1'b0;
          end else begin
            prev_ext   <= ext;
            seen_first <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/srbf_checker.sv @@
`include "short_run_boundary_flattener_assert.svh"

module srbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_lat
);

  // a station transfer starts the sequencer, so no back-to-back station
  `SRBF_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

  // nothing new is loaded while waiting for a station
  `SRBF_ASSERT_NEXT(a_idle_drains, in_ready && out_valid && out_ready, !out_valid)

  // stalled result holds its value
  `SRBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_lat))

  // out of reset the block is empty and waiting
  `SRBF_ASSERT_NEXT_RST(a_reset_state, rst, !out_valid && in_ready)

endmodule

bind short_run_boundary_flattener srbf_checker u_srbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (stations.valid),
  .in_ready  (stations.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_lat   (results.outer_lat_out)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH       = 32;
  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [20:0] pos;
    logic signed [16:0] inner;
    logic signed [16:0] outer;
    logic               fin;
  } station_t;

  typedef struct packed {
    logic signed [16:0] outer;
    logic               replaced;
    logic               fin;
  } bound_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [srbf_pkg::PADDR_W-1:0] paddr;
  logic [srbf_pkg::PDATA_W-1:0] pwdata;
  logic [srbf_pkg::PDATA_W-1:0] prdata;
  logic pready;

  srbf_in_if  stn_if ();
  srbf_out_if res_if ();

  short_run_boundary_flattener #(
    .RUN_DEPTH(DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .stations(stn_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  station_t station_q[$];
  bound_t   bound_due_q[$];
  station_t drive_st;
  bound_t   due;

  // flattener model state
  logic [srbf_pkg::THR_W-1:0] thr_cfg = srbf_pkg::THR_RESET;
  logic [srbf_pkg::LEN_W-1:0] len_cfg = srbf_pkg::LEN_RESET;
  logic signed [16:0] run_buf[DEPTH];
  int  run_len      = 0;
  bit  run_active   = 1'b0;
  int  run_s0       = 0;
  int  run_s1       = 0;
  logic signed [16:0] pre_outer = '0;
  bit  last_was_ext = 1'b0;
  bit  list_started = 1'b0;

  int  snd_pct = 0;
  int  rcv_pct = 0;
  bit  stn_took = 1'b0;
  bit  hold_go = 1'b0;
  bit  rx_hold = 1'b0;

  int  stations_queued = 0;
  int  stations_taken  = 0;
  int  results_n       = 0;
  int  lists_n         = 0;
  int  flattened_n     = 0;
  int  overflow_n      = 0;
  int  stall_n         = 0;
  int  mismatches      = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #800000;
    $display("Simulation FAILED");
    $finish;
  end

  // long receiver hold-off so the station input backs up
  initial begin
    @(posedge hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %0s: got %0d want %0d at result %0d", what, got, want, results_n);
    mismatches++;
  endtask

  function automatic void push_bound(input logic signed [16:0] v, input logic rep);
    bound_t b;
    b = '{v, rep, 1'b0};
    bound_due_q.insert(bound_due_q.size(), b);
    if (rep) flattened_n++;
  endfunction

  function automatic void release_run(input bit flatten);
    int i;
    for (i = 0; i < run_len; i++)
      push_bound(flatten ? pre_outer : run_buf[i], flatten);
    run_len = 0;
    run_active = 1'b0;
  endfunction

  function automatic void predict_outer_bounds(input logic signed [20:0] pos,
                                               input logic signed [16:0] inner,
                                               input logic signed [16:0] outer,
                                               input logic fin);
    int gap;
    int agap;
    int span;
    int n0;
    bit ext;
    gap  = int'(inner) - int'(outer);
    agap = gap < 0 ? -gap : gap;
    ext  = agap > int'(thr_cfg);
    n0   = bound_due_q.size();
    if (run_active) begin
      if (ext) begin
        if (run_len < DEPTH) begin
          run_buf[run_len] = outer;
          run_len++;
          run_s1 = pos;
          if (fin) release_run(1'b0);
        end else begin
          // store full: pass everything through and drop the run
          overflow_n++;
          release_run(1'b0);
          push_bound(outer, 1'b0);
          pre_outer = outer;
        end
      end else begin
        span = run_s1 - run_s0;
        release_run(span <= int'(len_cfg));
        push_bound(outer, 1'b0);
        pre_outer = outer;
      end
    end else if (ext && list_started && !last_was_ext) begin
      run_active = 1'b1;
      run_s0 = pos;
      run_s1 = pos;
      run_buf[0] = outer;
      run_len = 1;
      if (fin) release_run(1'b0);
    end else begin
      push_bound(outer, 1'b0);
      pre_outer = outer;
    end
    if (fin) begin
      if (bound_due_q.size() > n0) bound_due_q[bound_due_q.size() - 1].fin = 1'b1;
      lists_n++;
      run_len = 0;
      run_active = 1'b0;
      run_s0 = 0;
      run_s1 = 0;
      pre_outer = '0;
      last_was_ext = 1'b0;
      list_started = 1'b0;
    end else begin
      last_was_ext = ext;
      list_started = 1'b1;
    end
  endfunction

  // station driver
  always @(negedge clk) begin
    if (rst) begin
      stn_if.valid <= 1'b0;
    end else if (!stn_if.valid || stn_took) begin
      if (station_q.size() != 0 && $urandom_range(99, 0) >= snd_pct) begin
        drive_st = station_q.pop_front();
        stn_if.station_s    <= drive_st.pos;
        stn_if.inner_lat    <= drive_st.inner;
        stn_if.outer_lat    <= drive_st.outer;
        stn_if.last_station <= drive_st.fin;
        stn_if.valid        <= 1'b1;
      end else begin
        stn_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !rx_hold && ($urandom_range(99, 0) >= rcv_pct);
    end
  end

  // monitor: model on station transfer, compare on result transfer
  always @(posedge clk) begin
    if (rst) begin
      stn_took <= 1'b0;
    end else begin
      stn_took <= stn_if.valid && stn_if.ready;
      if (stn_if.valid && !stn_if.ready) stall_n++;
      if (stn_if.valid && stn_if.ready) begin
        predict_outer_bounds(stn_if.station_s, stn_if.inner_lat, stn_if.outer_lat,
                             stn_if.last_station);
        stations_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        if (bound_due_q.size() == 0) begin
          report_mismatch("result with nothing due", res_if.outer_lat_out, 0);
        end else begin
          due = bound_due_q.pop_front();
          if (res_if.outer_lat_out !== due.outer)
            report_mismatch("outer_lat_out", res_if.outer_lat_out, due.outer);
          if (res_if.was_replaced !== due.replaced)
            report_mismatch("was_replaced", res_if.was_replaced, due.replaced);
          if (res_if.last_result !== due.fin)
            report_mismatch("last_result", res_if.last_result, due.fin);
        end
        results_n++;
      end
    end
  end

  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == srbf_pkg::REG_THR) thr_cfg = value[srbf_pkg::THR_W-1:0];
    else len_cfg = value[srbf_pkg::LEN_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_station(input int pos, input int inner, input int outer, input bit fin);
    station_t st;
    st = '{pos[20:0], inner[16:0], outer[16:0], fin};
    station_q.insert(station_q.size(), st);
    stations_queued++;
  endtask

  task automatic wait_quiet();
    while (stations_taken != stations_queued || bound_due_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // lists of alternating plain and extended stretches, with some noise
  task automatic queue_random_lists(input int n_items, input bit with_overflow);
    int made;
    int n_list;
    int seg;
    int step_max;
    int step;
    int thr;
    int gap;
    int lo;
    int k;
    bit ext;
    bit big;
    logic signed [20:0] s_v;
    logic signed [16:0] in_v;
    logic signed [16:0] out_v;
    made = 0;
    big = with_overflow;
    thr = int'(thr_cfg);
    while (made < n_items) begin
      n_list = big ? DEPTH + 6 : (($urandom_range(7, 0) == 0) ? 1 : $urandom_range(20, 2));
      s_v = 21'($urandom);
      ext = big ? 1'b1 : 1'($urandom_range(1, 0));
      seg = 0;
      step_max = 0;
      for (k = 0; k < n_list; k++) begin
        if (seg == 0) begin
          ext = !ext;
          if (ext && big) begin
            seg = DEPTH + 2;
            big = 1'b0;
          end else begin
            seg = ext ? $urandom_range(5, 1) : $urandom_range(3, 1);
          end
          step_max = ext ? (2 * int'(len_cfg)) / seg + 1 : 4000;
        end
        if (ext)
          gap = thr + 1 + (($urandom_range(3, 0) == 0) ? 0 : int'($urandom_range(20000, 0)));
        else
          gap = ($urandom_range(3, 0) == 0) ? thr : int'($urandom_range(thr, 0));
        lo = int'($urandom_range(131071 - gap, 0)) - 65536;
        if ($urandom_range(1, 0) == 1) begin
          in_v = 17'(lo + gap);
          out_v = 17'(lo);
        end else begin
          in_v = 17'(lo);
          out_v = 17'(lo + gap);
        end
        if ($urandom_range(9, 0) == 0)
          queue_station($urandom, $urandom, $urandom, k == n_list - 1);
        else
          queue_station(s_v, in_v, out_v, k == n_list - 1);
        step = $urandom_range(step_max, 0);
        if ($urandom_range(7, 0) == 0) step = -step;
        s_v = 21'(s_v + step);
        seg--;
      end
      made += n_list;
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    snd_pct = 24;
    rcv_pct = 48;
    write_reg(srbf_pkg::REG_THR, 32'(srbf_pkg::THR_RESET));
    write_reg(srbf_pkg::REG_LEN, 32'(srbf_pkg::LEN_RESET));
    @(posedge clk);
    // single-station lists at the field extremes
    queue_station(-1048576, 65535, -65536, 1'b1);
    queue_station(1048575, -65536, 65535, 1'b1);
    // extended first station, back-to-back extended, gap at threshold
    queue_station(0, 2000, 0, 1'b0);
    queue_station(100, 0, -1700, 1'b0);
    queue_station(200, 1650, 0, 1'b0);
    // run spanning exactly the short length gets flattened
    queue_station(1000, 5000, 1000, 1'b0);
    queue_station(2500, -3000, 0, 1'b0);
    queue_station(4000, 9000, 2000, 1'b0);
    queue_station(4100, 10, 20, 1'b0);
    // one mm too long, passes unchanged
    queue_station(5000, 4000, 100, 1'b0);
    queue_station(8001, -2000, 0, 1'b0);
    queue_station(8100, 50, 0, 1'b0);
    // run going backwards counts as short
    queue_station(9000, 65535, -65536, 1'b0);
    queue_station(8000, -65536, 65535, 1'b0);
    queue_station(9500, -5, -5, 1'b0);
    // run still open at list end
    queue_station(10000, 1651, 0, 1'b0);
    queue_station(10500, 0, 3000, 1'b1);
    // run opening on the final station
    queue_station(0, 0, 0, 1'b0);
    queue_station(10, 0, 4000, 1'b1);
    wait_quiet();

    write_reg(srbf_pkg::REG_THR, 32'd0);
    write_reg(srbf_pkg::REG_LEN, 32'd0);
    @(posedge clk);
    queue_random_lists(50, 1'b0);
    wait_quiet();

    @(posedge clk);
    snd_pct = 48;
    rcv_pct = 24;
    write_reg(srbf_pkg::REG_THR, 32'd8191);
    write_reg(srbf_pkg::REG_LEN, 32'd65535);
    @(posedge clk);
    queue_random_lists(50, 1'b1);
    hold_go = 1'b1;
    wait_quiet();

    @(posedge clk);
    snd_pct = 0;
    rcv_pct = 0;
    write_reg(srbf_pkg::REG_THR, $urandom_range(3000, 200));
    write_reg(srbf_pkg::REG_LEN, $urandom_range(65535, 0));
    @(posedge clk);
    queue_random_lists(50, 1'b1);
    wait_quiet();

    $display("covered %0d stations in %0d lists, %0d results checked, %0d input stall cycles",
             stations_taken, lists_n, results_n, stall_n);
    $display("%0d outer bounds flattened, %0d run store overflows", flattened_n, overflow_n);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
